>>> rtl/core/tdss_pkg.sv
// Shared types and constants for the transmit descriptor slot scheduler.
// No dependencies; every other file of the block except tdss_ram refers to this package.
`default_nettype none

package tdss_pkg;

    // Default configuration of the descriptor ring.
    localparam int SLOT_COUNT_DEF   = 4;
    localparam int ADDRESS_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF  = 16;

    // Fixed field widths of the result beat.
    localparam int OUTCOME_W = 3;
    localparam int OFFSET_W  = 2;

    // Result codes of one beat.
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED  = 3'd0,
        OUT_ACCEPTED = 3'd1,
        OUT_FULL     = 3'd2,
        OUT_ISSUED   = 3'd3,
        OUT_RELEASED = 3'd4,
        OUT_DRAINED  = 3'd5
    } outcome_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/transmit_descriptor_slot_scheduler_top.sv
// A beat accepted while idle is captured with a registered read of the descriptor memory,
// then executed in ST_EXEC; its result strobe (done) is registered from that state.
// No new beat is taken before the last one is executed; busy is high in the execute state.
// Every beat gives exactly one result, shown for one cycle; the receiver cannot stall.
// Reset (rst_n low, asynchronous) frees all slots, selects slot 0 and disables transmission.
// Depends on tdss_pkg, tdss_ctrl, tdss_dp and tdss_ram.
`default_nettype none

module transmit_descriptor_slot_scheduler_top #(
    parameter int SLOT_COUNT   = tdss_pkg::SLOT_COUNT_DEF,
    parameter int ADDRESS_BITS = tdss_pkg::ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = tdss_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           action,
    input  wire logic [ADDRESS_BITS-1:0]        start_address,
    input  wire logic [LENGTH_BITS-1:0]         byte_count,
    output logic                                done,
    output logic      [tdss_pkg::OUTCOME_W-1:0] outcome,
    output logic      [tdss_pkg::OFFSET_W-1:0]  slot_offset,
    output logic      [ADDRESS_BITS-1:0]        byte_address,
    output logic                                transmit_active
);

    tdss_pkg::dp_cmd_t cmd;

    tdss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    tdss_dp #(
        .SLOT_COUNT   (SLOT_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .action          (action),
        .start_address   (start_address),
        .byte_count      (byte_count),
        .done            (done),
        .outcome         (outcome),
        .slot_offset     (slot_offset),
        .byte_address    (byte_address),
        .transmit_active (transmit_active)
    );

endmodule

`default_nettype wire

>>> rtl/core/tdss_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module tdss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/tdss_ctrl.sv
// Controller of the descriptor slot scheduler: two-state sequencer.
// Depends on tdss_pkg for the state type and the datapath command struct.
`default_nettype none

module tdss_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output tdss_pkg::dp_cmd_t     cmd
);

    tdss_pkg::state_t state_reg;
    tdss_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands: capture the beat and read the current slot, then execute.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        unique case (state_reg)
            tdss_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tdss_pkg::ST_EXEC;
                end
            end
            tdss_pkg::ST_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = tdss_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tdss_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A captured beat is executed in the very next cycle.
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("captured beat not executed next cycle");

    // A new beat is never captured while one is executing.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !cmd.capture)
        else $error("capture during execute");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tdss_dp.sv
// Datapath of the descriptor slot scheduler: busy bits, current slot, descriptor
// memory, circular scans and the result register. Depends on tdss_pkg and tdss_ram.
`default_nettype none

module tdss_dp #(
    parameter int SLOT_COUNT   = tdss_pkg::SLOT_COUNT_DEF,
    parameter int ADDRESS_BITS = tdss_pkg::ADDRESS_BITS_DEF,
    parameter int LENGTH_BITS  = tdss_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tdss_pkg::dp_cmd_t                  cmd,
    input  wire logic                               action,
    input  wire logic [ADDRESS_BITS-1:0]            start_address,
    input  wire logic [LENGTH_BITS-1:0]             byte_count,
    output logic                                    done,
    output logic      [tdss_pkg::OUTCOME_W-1:0]     outcome,
    output logic      [tdss_pkg::OFFSET_W-1:0]      slot_offset,
    output logic      [ADDRESS_BITS-1:0]            byte_address,
    output logic                                    transmit_active
);

    localparam int CW = $clog2(SLOT_COUNT);
    localparam int KW = (CW > tdss_pkg::OFFSET_W) ? CW : tdss_pkg::OFFSET_W;
    localparam int DW = ADDRESS_BITS + LENGTH_BITS;

    // Control state.
    logic [SLOT_COUNT-1:0] slot_busy_reg, slot_busy_next;
    logic [CW-1:0]         cur_reg, cur_next;
    logic                  tx_reg, tx_next;
    logic                  done_reg;

    // Captured input beat.
    logic                    action_reg;
    logic [ADDRESS_BITS-1:0] addr_in_reg;
    logic [LENGTH_BITS-1:0]  count_in_reg;

    // Result payload.
    tdss_pkg::outcome_t           outcome_reg, outcome_next;
    logic [tdss_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [ADDRESS_BITS-1:0]      baddr_reg, baddr_next;

    // Descriptor memory access.
    logic                    mem_we;
    logic [CW-1:0]           mem_waddr;
    logic [DW-1:0]           mem_wdata;
    logic [DW-1:0]           mem_rdata;
    logic [DW-1:0]           slot_word;
    logic [ADDRESS_BITS-1:0] slot_addr;
    logic [LENGTH_BITS-1:0]  slot_rem;

    // Scan results.
    logic [CW:0]   slot_sum;
    logic          free_found;
    logic [KW-1:0] free_k;
    logic [CW-1:0] free_idx;
    logic          next_found;
    logic [CW-1:0] next_idx;

    tdss_ram #(
        .WIDTH (DW),
        .DEPTH (SLOT_COUNT)
    ) u_desc_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (cmd.capture),
        .raddr (cur_reg),
        .rdata (mem_rdata)
    );

    // A slot that is not busy reads as an empty descriptor.
    assign slot_word = slot_busy_reg[cur_reg] ? mem_rdata : '0;
    assign slot_rem  = slot_word[LENGTH_BITS-1:0];
    assign slot_addr = slot_word[DW-1:LENGTH_BITS];

    // Circular scans from the current slot: first free slot, and next busy slot after the current one.
    always_comb
    begin
        free_found = 1'b0;
        free_k     = '0;
        free_idx   = '0;
        next_found = 1'b0;
        next_idx   = '0;
        slot_sum   = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--)
        begin
            slot_sum = {1'b0, cur_reg} + (CW+1)'(k);
            if (slot_sum >= (CW+1)'(SLOT_COUNT))
            begin
                slot_sum = slot_sum - (CW+1)'(SLOT_COUNT);
            end
            if (!slot_busy_reg[slot_sum[CW-1:0]])
            begin
                free_found = 1'b1;
                free_k     = KW'(k);
                free_idx   = slot_sum[CW-1:0];
            end
            if (k != 0 && slot_busy_reg[slot_sum[CW-1:0]])
            begin
                next_found = 1'b1;
                next_idx   = slot_sum[CW-1:0];
            end
        end
    end

    // Execution of one beat.
    always_comb
    begin
        slot_busy_next = slot_busy_reg;
        cur_next       = cur_reg;
        tx_next        = tx_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = {addr_in_reg, count_in_reg};
        outcome_next   = tdss_pkg::OUT_IGNORED;
        offset_next    = '0;
        baddr_next     = '0;
        if (!action_reg)
        begin
            // Submit: store in the first free slot or report a full ring.
            outcome_next = tdss_pkg::OUT_FULL;
            if (free_found)
            begin
                slot_busy_next[free_idx] = 1'b1;
                mem_we       = 1'b1;
                mem_waddr    = free_idx;
                tx_next      = 1'b1;
                outcome_next = tdss_pkg::OUT_ACCEPTED;
                offset_next  = free_k[tdss_pkg::OFFSET_W-1:0];
            end
        end
        else if (tx_reg)
        begin
            if (slot_rem != '0)
            begin
                // Issue the next byte and count down.
                mem_we       = 1'b1;
                mem_wdata    = {slot_addr + ADDRESS_BITS'(1), slot_rem - LENGTH_BITS'(1)};
                outcome_next = tdss_pkg::OUT_ISSUED;
                baddr_next   = slot_addr;
            end
            else
            begin
                // Release the finished slot and move on, or go idle.
                slot_busy_next[cur_reg] = 1'b0;
                if (next_found)
                begin
                    cur_next     = next_idx;
                    outcome_next = tdss_pkg::OUT_RELEASED;
                end
                else
                begin
                    tx_next      = 1'b0;
                    outcome_next = tdss_pkg::OUT_DRAINED;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg <= '0;
            cur_reg       <= '0;
            tx_reg        <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
            if (cmd.execute)
            begin
                slot_busy_reg <= slot_busy_next;
                cur_reg       <= cur_next;
                tx_reg        <= tx_next;
            end
        end
    end

    // Input beat and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg   <= action;
            addr_in_reg  <= start_address;
            count_in_reg <= byte_count;
        end
        if (cmd.execute)
        begin
            outcome_reg <= outcome_next;
            offset_reg  <= offset_next;
            baddr_reg   <= baddr_next;
        end
    end

    assign done            = done_reg;
    assign outcome         = outcome_reg;
    assign slot_offset     = offset_reg;
    assign byte_address    = baddr_reg;
    assign transmit_active = tx_reg;

`ifndef SYNTH
    // Any busy slot means transmission is enabled.
    a_busy_implies_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (|slot_busy_reg) |-> tx_reg)
        else $error("busy slot while transmission disabled");

    // A drained ring leaves no busy slot and transmission off.
    a_drained_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && outcome_reg == tdss_pkg::OUT_DRAINED) |-> (!tx_reg && slot_busy_reg == '0))
        else $error("drained result with work left");

    // An accepted submit always leaves transmission on.
    a_accept_active: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && outcome_reg == tdss_pkg::OUT_ACCEPTED) |-> tx_reg)
        else $error("accepted submit without transmission");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the transmit descriptor slot scheduler top level.
// A driver feeds submit and transmitter-ready beats, and a monitor checks every result beat.
// Depends on tdss_pkg and transmit_descriptor_slot_scheduler_top.
`default_nettype none

module testbench;

    localparam int SLOTS = tdss_pkg::SLOT_COUNT_DEF;
    localparam int AW    = tdss_pkg::ADDRESS_BITS_DEF;
    localparam int LW    = tdss_pkg::LENGTH_BITS_DEF;

    // Action codes of an input beat.
    localparam logic ACT_SUBMIT = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Beats before which the driver waits until every outstanding result has been checked.
    localparam int HOLD_AT_A = 500;
    localparam int HOLD_AT_B = 900;

    // Number of random beats to generate after the directed part.
    localparam int RANDOM_BEATS = 1000;

    typedef struct {
        logic          act;
        logic [AW-1:0] addr;
        logic [LW-1:0] count;
        logic          hold;
    } command_t;

    typedef struct {
        tdss_pkg::outcome_t            outcome;
        logic [tdss_pkg::OFFSET_W-1:0] offset;
        logic [AW-1:0]                 address;
        logic                          active;
    } tx_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic          start         = 1'b0;
    logic          action        = ACT_SUBMIT;
    logic [AW-1:0] start_address = '0;
    logic [LW-1:0] byte_count    = '0;

    logic                           busy;
    logic                           done;
    logic [tdss_pkg::OUTCOME_W-1:0] outcome;
    logic [tdss_pkg::OFFSET_W-1:0]  slot_offset;
    logic [AW-1:0]                  byte_address;
    logic                           transmit_active;

    command_t   command_queue[$];
    tx_result_t pending_results[$];
    int         beats_sent  = 0;
    int         error_count = 0;

    // Shadow copy of the descriptor ring.
    logic          slot_used [SLOTS];
    logic [AW-1:0] slot_addr [SLOTS];
    logic [LW-1:0] slot_left [SLOTS];
    int            current_slot;
    logic          tx_enabled;

    transmit_descriptor_slot_scheduler_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .start_address   (start_address),
        .byte_count      (byte_count),
        .done            (done),
        .outcome         (outcome),
        .slot_offset     (slot_offset),
        .byte_address    (byte_address),
        .transmit_active (transmit_active)
    );

    // Clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one beat to the shadow ring and returns the result it should produce.
    function automatic tx_result_t advance_ring(input logic act, input logic [AW-1:0] addr,
                                                input logic [LW-1:0] count);
        tx_result_t res;
        int         cur;
        int         idx;
        int         k;
        logic       found;
        res.outcome = tdss_pkg::OUT_IGNORED;
        res.offset  = '0;
        res.address = '0;
        cur         = current_slot;
        found       = 1'b0;
        if (act == ACT_SUBMIT)
        begin
            // Store in the first free slot, looking from the current one onward.
            res.outcome = tdss_pkg::OUT_FULL;
            for (k = 0; k < SLOTS; k++)
            begin
                idx = (cur + k) % SLOTS;
                if (!found && !slot_used[idx])
                begin
                    found          = 1'b1;
                    slot_used[idx] = 1'b1;
                    slot_addr[idx] = addr;
                    slot_left[idx] = count;
                    tx_enabled     = 1'b1;
                    res.outcome    = tdss_pkg::OUT_ACCEPTED;
                    res.offset     = k[tdss_pkg::OFFSET_W-1:0];
                end
            end
        end
        else if (tx_enabled)
        begin
            if (slot_left[cur] != '0)
            begin
                // Issue the next byte and count down; the address wraps.
                res.address    = slot_addr[cur];
                slot_addr[cur] = slot_addr[cur] + 1'b1;
                slot_left[cur] = slot_left[cur] - 1'b1;
                res.outcome    = tdss_pkg::OUT_ISSUED;
            end
            else
            begin
                // Free the finished slot and move on to the next busy one, if any.
                slot_used[cur] = 1'b0;
                slot_addr[cur] = '0;
                slot_left[cur] = '0;
                res.outcome    = tdss_pkg::OUT_DRAINED;
                for (k = 1; k < SLOTS; k++)
                begin
                    idx = (current_slot + k) % SLOTS;
                    if (!found && slot_used[idx])
                    begin
                        found       = 1'b1;
                        cur         = idx;
                        res.outcome = tdss_pkg::OUT_RELEASED;
                    end
                end
                if (!found)
                    tx_enabled = 1'b0;
            end
        end
        current_slot = cur;
        res.active   = tx_enabled;
        return res;
    endfunction

    function automatic void queue_command(input logic act, input logic [AW-1:0] addr,
                                          input logic [LW-1:0] count);
        command_t c;
        c.act   = act;
        c.addr  = addr;
        c.count = count;
        c.hold  = (command_queue.size() == HOLD_AT_A) || (command_queue.size() == HOLD_AT_B);
        command_queue.push_back(c);
    endfunction

    function automatic void queue_tick();
        queue_command(ACT_TICK, AW'($urandom), LW'($urandom));
    endfunction

    // Driver: presents beats from the command queue, idling at random except while beats 300 to 519 are sent.
    always @(posedge clk)
    begin : driver
        command_t c;
        logic     no_idle;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                pending_results.push_back(advance_ring(action, start_address, byte_count));
                beats_sent++;
            end
            if (!start || !busy)
            begin
                no_idle = (beats_sent >= 300) && (beats_sent < 520);
                if (command_queue.size() != 0
                    && !(command_queue[0].hold && pending_results.size() != 0)
                    && (no_idle || $urandom_range(0, 99) >= 26))
                begin
                    c = command_queue.pop_front();
                    start         <= 1'b1;
                    action        <= c.act;
                    start_address <= c.addr;
                    byte_count    <= c.count;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        tx_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, outcome %0d", $time, outcome);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome)
                begin
                    $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
                    error_count++;
                end
                if (slot_offset !== want.offset)
                begin
                    $display("%0t: slot_offset expected %0d actual %0d",
                             $time, want.offset, slot_offset);
                    error_count++;
                end
                if (byte_address !== want.address)
                begin
                    $display("%0t: byte_address expected %h actual %h",
                             $time, want.address, byte_address);
                    error_count++;
                end
                if (transmit_active !== want.active)
                begin
                    $display("%0t: transmit_active expected %b actual %b",
                             $time, want.active, transmit_active);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        int i;
        int n;
        int need;
        int cnt;
        int random_beats;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_addr[i] = '0;
            slot_left[i] = '0;
        end
        current_slot = 0;
        tx_enabled   = 1'b0;

        // Directed part. A tick while disabled is ignored.
        queue_command(ACT_TICK, '1, '1);
        // Fill the ring; the first descriptor wraps its address.
        queue_command(ACT_SUBMIT, 32'hFFFF_FFFE, 16'd3);
        queue_command(ACT_SUBMIT, '0, '0);
        queue_command(ACT_SUBMIT, 32'h1234_5678, 16'd1);
        queue_command(ACT_SUBMIT, 32'hA5A5_A5A5, 16'd2);
        // One more submit finds the ring full.
        queue_command(ACT_SUBMIT, 32'h5A5A_5A5A, 16'd7);
        // Drain everything: issues, releases, the zero-length slot, then the drained case.
        repeat (11) queue_tick();
        queue_tick();
        // After draining, the current slot is the last one, so the free-slot search wraps around.
        queue_command(ACT_SUBMIT, 32'h0000_0001, '0);
        queue_command(ACT_SUBMIT, 32'h8000_0000, 16'd1);
        queue_command(ACT_SUBMIT, 32'h7FFF_FFFF, 16'd0);
        repeat (6) queue_tick();

        // Random part: mostly submit bursts followed by ticks to drain them.
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                n    = $urandom_range(1, 5);
                need = 0;
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        cnt = $urandom_range(8, 40);
                    else
                        cnt = $urandom_range(0, 6);
                    queue_command(ACT_SUBMIT, AW'($urandom), cnt[LW-1:0]);
                    need += cnt + 1;
                end
                // Sometimes leave work behind for the next burst.
                if ($urandom_range(0, 4) == 0)
                    need = $urandom_range(0, need);
                else
                    need += $urandom_range(0, 2);
                repeat (need) queue_tick();
                random_beats += n + need;
            end
            else
            begin
                if ($urandom_range(0, 1) == 1)
                    queue_tick();
                else
                    queue_command(ACT_SUBMIT, AW'($urandom), LW'($urandom_range(0, 15)));
                random_beats++;
            end
        end

        // Last, a full-length descriptor so that every count bit is set once.
        queue_command(ACT_SUBMIT, AW'($urandom), '1);
        repeat (20) queue_tick();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || start)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (error_count == 0)
            $display("[transmit_descriptor_slot_scheduler_top] OK");
        else
            $display("[transmit_descriptor_slot_scheduler_top] ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #400000;
        $display("[transmit_descriptor_slot_scheduler_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
